### src/pimt_pkg.sv
// Shared types, codes and constants of the protected identifier match table.
`default_nettype none

package pimt_pkg;

	// Default number of table slots
	localparam int DEFAULT_SLOTS = 10;

	// Field widths
	localparam int ACTION_W = 3;
	localparam int IDENT_W  = 32;
	localparam int LEN_W    = 16;
	localparam int ACCESS_W = 32;
	localparam int STATUS_W = 3;
	localparam int BYTES_W  = 3;
	localparam int ENTRY_W  = 4;

	// Stream bus widths
	localparam int S_DATA_W = 80;
	localparam int S_USER_W = 4;
	localparam int M_DATA_W = 40;
	localparam int M_USER_W = 3;

	// Request codes
	localparam logic [ACTION_W-1:0] ACT_PROTECT   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_UNPROTECT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CHECK     = 3'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] STS_BAD_LENGTH  = 3'd1;
	localparam logic [STATUS_W-1:0] STS_ZERO_IDENT  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FULL        = 3'd3;
	localparam logic [STATUS_W-1:0] STS_EMPTY       = 3'd4;
	localparam logic [STATUS_W-1:0] STS_BAD_REQUEST = 3'd5;

	// Byte count reported on a completed protect or unprotect
	localparam logic [BYTES_W-1:0] BYTES_DONE_OK = 3'd4;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EXEC
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming request beat
		logic look;     // compare all slots, register the hit vectors
		logic exec;     // update the table and load the result register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free; // result register empty or draining this cycle
	} stat_t;

endpackage

`default_nettype wire

### src/pimt_ctrl.sv
// Controller state machine sequencing capture, compare and update of one request.
`default_nettype none

module pimt_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_tvalid,
	output logic            s_tready,
	input  pimt_pkg::stat_t stat,
	output pimt_pkg::cmd_t  cmd
);

	pimt_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pimt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.look    = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			pimt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = pimt_pkg::ST_LOOK;
				end
			end
			pimt_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = pimt_pkg::ST_EXEC;
			end
			pimt_pkg::ST_EXEC: begin
				// hold until the result register can take the new beat
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = pimt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pimt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/pimt_dp.sv
// Datapath: request latch, slot table, parallel compare, update and result register.
`default_nettype none

module pimt_dp #(
	parameter int SLOTS = pimt_pkg::DEFAULT_SLOTS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [pimt_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire  [pimt_pkg::S_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [pimt_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [pimt_pkg::M_USER_W-1:0]  m_tuser,
	input  pimt_pkg::cmd_t                 cmd,
	output pimt_pkg::stat_t                stat
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = (CW > pimt_pkg::ENTRY_W) ? CW : pimt_pkg::ENTRY_W;
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	// Latched request
	logic [pimt_pkg::ACTION_W-1:0] action_q;
	logic [pimt_pkg::IDENT_W-1:0]  ident_q;
	logic [pimt_pkg::LEN_W-1:0]    length_q;
	logic                          kernel_q;
	logic [pimt_pkg::ACCESS_W-1:0] access_q;

	// Table and count
	logic [pimt_pkg::IDENT_W-1:0] slot_q [SLOTS];
	logic [CW-1:0]                used_q, used_d;

	// Registered compare results
	logic [SLOTS-1:0] hit_vec_q, empty_vec_q;

	// Result register
	logic                          out_valid_q;
	logic [pimt_pkg::STATUS_W-1:0] status_q, status_d;
	logic [pimt_pkg::BYTES_W-1:0]  bytes_q, bytes_d;
	logic [pimt_pkg::ACCESS_W-1:0] acc_out_q, acc_out_d;
	logic                          matched_q, matched_d;
	logic [pimt_pkg::ENTRY_W-1:0]  entries_q;
	logic [EW-1:0]                 used_ext;

	// Table update controls
	logic [SLOTS-1:0]             first_hit, first_empty, wr_vec;
	logic [pimt_pkg::IDENT_W-1:0] wr_val;
	logic                         clr_all;

	// Request latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= s_tuser[2:0];
			kernel_q <= s_tuser[3];
			ident_q  <= s_tdata[31:0];
			length_q <= s_tdata[47:32];
			access_q <= s_tdata[79:48];
		end
	end

	// Compare every slot against the identifier and against empty
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			for (int i = 0; i < SLOTS; i++) begin
				hit_vec_q[i]   <= (slot_q[i] == ident_q);
				empty_vec_q[i] <= (slot_q[i] == '0);
			end
		end
	end

	// Lowest set bit of each vector
	assign first_hit   = hit_vec_q & (~hit_vec_q + 1'b1);
	assign first_empty = empty_vec_q & (~empty_vec_q + 1'b1);

	// Request decode
	always_comb begin
		status_d  = pimt_pkg::STS_OK;
		bytes_d   = '0;
		acc_out_d = '0;
		matched_d = 1'b0;
		used_d    = used_q;
		wr_vec    = '0;
		wr_val    = '0;
		clr_all   = 1'b0;
		unique case (action_q)
			pimt_pkg::ACT_PROTECT, pimt_pkg::ACT_UNPROTECT: begin
				if (length_q[1:0] != 2'b00) begin
					status_d = pimt_pkg::STS_BAD_LENGTH;
				end else if (ident_q == '0) begin
					status_d = pimt_pkg::STS_ZERO_IDENT;
				end else if (action_q == pimt_pkg::ACT_PROTECT) begin
					if (used_q >= SLOTS_C) begin
						status_d = pimt_pkg::STS_FULL;
					end else begin
						bytes_d = pimt_pkg::BYTES_DONE_OK;
						if (|empty_vec_q) begin
							wr_vec = first_empty;
							wr_val = ident_q;
							used_d = used_q + 1'b1;
						end
					end
				end else begin
					if (used_q == '0) begin
						status_d = pimt_pkg::STS_EMPTY;
					end else begin
						bytes_d = pimt_pkg::BYTES_DONE_OK;
						// absent identifier still succeeds
						if (|hit_vec_q) begin
							wr_vec = first_hit;
							used_d = used_q - 1'b1;
						end
					end
				end
			end
			pimt_pkg::ACT_CLEAR: begin
				clr_all = 1'b1;
				used_d  = '0;
			end
			pimt_pkg::ACT_CHECK: begin
				acc_out_d = access_q;
				// identifier zero matches any empty slot
				if (!kernel_q && (|hit_vec_q)) begin
					matched_d    = 1'b1;
					acc_out_d[0] = 1'b0;
				end
			end
			default: begin
				status_d = pimt_pkg::STS_BAD_REQUEST;
			end
		endcase
	end

	// Table and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			used_q <= used_d;
			for (int i = 0; i < SLOTS; i++) begin
				if (clr_all) begin
					slot_q[i] <= '0;
				end else if (wr_vec[i]) begin
					slot_q[i] <= wr_val;
				end
			end
		end
	end

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Count wraps to its low bits on wide tables
	assign used_ext = EW'(used_d);

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= status_d;
			bytes_q   <= bytes_d;
			acc_out_q <= acc_out_d;
			matched_q <= matched_d;
			entries_q <= used_ext[pimt_pkg::ENTRY_W-1:0];
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tuser       = status_q;
	assign m_tdata       = {entries_q, matched_q, acc_out_q, bytes_q};

endmodule

`default_nettype wire

### src/protected_id_match_table.sv
// Top level of the protected identifier match table.
//
// A table of SLOTS 32-bit identifiers (zero marks an empty slot) with an
// occupancy count, cleared at reset. Each request beat on the slave side gives
// exactly one result beat on the master side. A request passes through the
// controller states idle, in which the beat is accepted and latched, look, in
// which every slot is compared in parallel against the identifier and against
// zero, and exec, in which the lowest matching or lowest empty slot is selected
// and written and the result register is loaded. Exec waits while the result
// register still holds a beat that is not taken. The controller takes one
// request at a time and accepts no new beat until the last one is through exec.
// A finished result waits in its own register while the next request is latched
// and compared.
`default_nettype none

module protected_id_match_table #(
	parameter int SLOTS = pimt_pkg::DEFAULT_SLOTS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// request stream
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [pimt_pkg::S_DATA_W-1:0]  s_tdata,  // ident[31:0], length_bytes[47:32],
	                                                 // access_in[79:48]
	input  wire  [pimt_pkg::S_USER_W-1:0]  s_tuser,  // action[2:0], kernel_origin[3]
	// result stream
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [pimt_pkg::M_DATA_W-1:0]  m_tdata,  // bytes_done[2:0], access_out[34:3],
	                                                 // matched[35], entries_used[39:36]
	output logic [pimt_pkg::M_USER_W-1:0]  m_tuser   // status[2:0]
);

	pimt_pkg::cmd_t  cmd;
	pimt_pkg::stat_t stat;

	// Sequencer
	pimt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Table and result path
	pimt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the protected identifier match table.
`timescale 1ns / 100ps

module tb;
	import pimt_pkg::*;

	localparam int SLOTS = DEFAULT_SLOTS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ID_POOL = 16;
	localparam int HOLD_OFF_CYCLES = 200;

	// First undefined request code; codes up to 7 are all undefined
	localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 3'd4;
	// Access bit that a matching check removes
	localparam logic [ACCESS_W-1:0] DENY_MASK = 32'h1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [IDENT_W-1:0]  ident;
		logic [LEN_W-1:0]    len;
		logic                kernel;
		logic [ACCESS_W-1:0] access;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTES_W-1:0]  bytes_done;
		logic [ACCESS_W-1:0] access_out;
		logic                matched;
		logic [ENTRY_W-1:0]  entries;
	} reply_t;

	// Table mirror plus queue of replies still owed by the block
	class id_table_scoreboard;
		logic [IDENT_W-1:0] slot_ids [SLOTS];
		int unsigned        used;
		reply_t             awaited_replies [$];
		int unsigned        errors;

		function new();
			wipe_table();
			errors = 0;
		endfunction

		function void wipe_table();
			foreach (slot_ids[i]) slot_ids[i] = '0;
			used = 0;
		endfunction

		// lowest slot holding key, -1 if none
		function int lookup(logic [IDENT_W-1:0] key);
			foreach (slot_ids[i]) begin
				if (slot_ids[i] == key) return i;
			end
			return -1;
		endfunction

		// Accepted request beat: update the mirror and queue the reply it causes
		function void note_request(request_t r);
			reply_t rep;
			int idx;
			rep = '0;
			rep.status = STS_OK;
			case (r.action)
				ACT_PROTECT, ACT_UNPROTECT: begin
					if (r.len[1:0] != 2'b00) begin
						rep.status = STS_BAD_LENGTH;
					end else if (r.ident == '0) begin
						rep.status = STS_ZERO_IDENT;
					end else if (r.action == ACT_PROTECT) begin
						if (used >= SLOTS) begin
							rep.status = STS_FULL;
						end else begin
							rep.bytes_done = BYTES_DONE_OK;
							idx = lookup('0);
							if (idx >= 0) begin
								slot_ids[idx] = r.ident;
								used++;
							end
						end
					end else begin
						if (used == 0) begin
							rep.status = STS_EMPTY;
						end else begin
							rep.bytes_done = BYTES_DONE_OK;
							idx = lookup(r.ident);
							if (idx >= 0) begin
								slot_ids[idx] = '0;
								used--;
							end
						end
					end
				end
				ACT_CLEAR: begin
					wipe_table();
				end
				ACT_CHECK: begin
					rep.access_out = r.access;
					if (!r.kernel && lookup(r.ident) >= 0) begin
						rep.matched = 1'b1;
						rep.access_out = r.access & ~DENY_MASK;
					end
				end
				default: begin
					rep.status = STS_BAD_REQUEST;
				end
			endcase
			rep.entries = used[ENTRY_W-1:0];
			awaited_replies.push_back(rep);
		endfunction

		function void report(string field, logic [ACCESS_W-1:0] want, logic [ACCESS_W-1:0] got);
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		endfunction

		// Accepted result beat: compare against the oldest queued reply
		function void check_result(logic [M_DATA_W-1:0] tdata, logic [M_USER_W-1:0] tuser);
			reply_t want;
			if (awaited_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, status %0h data %0h", $time, tuser, tdata);
				return;
			end
			want = awaited_replies.pop_front();
			if (tuser[2:0] != want.status) report("status", want.status, tuser[2:0]);
			if (tdata[2:0] != want.bytes_done) report("bytes_done", want.bytes_done, tdata[2:0]);
			if (tdata[34:3] != want.access_out) report("access_out", want.access_out, tdata[34:3]);
			if (tdata[35] != want.matched) report("matched", want.matched, tdata[35]);
			if (tdata[39:36] != want.entries) report("entries_used", want.entries, tdata[39:36]);
		endfunction

		function int unsigned outstanding();
			return awaited_replies.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_request = 0;
	logic [IDENT_W-1:0] id_pool [ID_POOL];
	id_table_scoreboard sb;

	protected_id_match_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result side: random stalls, plus long hold-offs counted here
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Result beat monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic request_t make_request(logic [ACTION_W-1:0] action,
	                                          logic [IDENT_W-1:0] ident,
	                                          logic [LEN_W-1:0] len, logic kernel,
	                                          logic [ACCESS_W-1:0] access);
		request_t r;
		r.action = action;
		r.ident  = ident;
		r.len    = len;
		r.kernel = kernel;
		r.access = access;
		return r;
	endfunction

	function automatic logic [IDENT_W-1:0] nonzero_ident();
		logic [IDENT_W-1:0] v;
		v = $urandom();
		if (v == '0) v = 32'h1;
		return v;
	endfunction

	// Mostly well-formed traffic over a small id pool so lookups hit
	function automatic request_t random_request();
		request_t r;
		int unsigned pick;
		if ($urandom_range(0, 15) == 0) id_pool[$urandom_range(0, ID_POOL-1)] = nonzero_ident();
		pick = $urandom_range(0, 99);
		if (pick < 38) r.action = ACT_PROTECT;
		else if (pick < 70) r.action = ACT_UNPROTECT;
		else if (pick < 92) r.action = ACT_CHECK;
		else if (pick < 95) r.action = ACT_CLEAR;
		else r.action = ACT_UNDEFINED | 3'($urandom_range(0, 3));
		pick = $urandom_range(0, 29);
		if (pick == 0) r.ident = '0;
		else if (pick == 1) r.ident = $urandom();
		else r.ident = id_pool[$urandom_range(0, ID_POOL-1)];
		r.len = $urandom_range(0, 16'hFFFF);
		if ($urandom_range(0, 11) != 0) r.len[1:0] = 2'b00;
		r.kernel = ($urandom_range(0, 4) == 0);
		r.access = $urandom();
		return r;
	endfunction

	// Offer one request beat and hold it until accepted
	task automatic send_request(input request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.access, r.len, r.ident};
		s_tuser  <= {r.kernel, r.action};
		do @(posedge clk); while (!s_tready);
		sb.note_request(r);
	endtask

	// Sender pauses until every owed reply has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned idle,
	                         input int unsigned stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (count) send_request(random_request());
		drain();
	endtask

	initial begin : stimulus
		sb = new();
		id_pool[0] = 32'hFFFF_FFFF;
		id_pool[1] = 32'h0000_0001;
		id_pool[2] = 32'h8000_0000;
		for (int i = 3; i < ID_POOL; i++) id_pool[i] = nonzero_ident();
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		@(posedge clk);

		// Directed: empty table, check order, fill to full, extremes, undefined codes
		send_request(make_request(ACT_UNPROTECT, 32'h1234, 16'd4, 1'b0, '0));
		send_request(make_request(ACT_CHECK, '0, 16'd0, 1'b0, 32'hFFFF_FFFF));
		send_request(make_request(ACT_CHECK, '0, 16'd0, 1'b1, 32'hFFFF_FFFF));
		send_request(make_request(ACT_PROTECT, 32'h5, 16'd1, 1'b0, '0));
		send_request(make_request(ACT_PROTECT, '0, 16'd3, 1'b0, '0));
		send_request(make_request(ACT_PROTECT, '0, 16'd0, 1'b0, '0));
		send_request(make_request(ACT_UNPROTECT, '0, 16'd2, 1'b0, '0));
		send_request(make_request(ACT_PROTECT, 32'hFFFF_FFFF, 16'hFFFC, 1'b1, 32'hFFFF_FFFF));
		send_request(make_request(ACT_PROTECT, 32'h1, 16'd0, 1'b0, '0));
		send_request(make_request(ACT_PROTECT, 32'h1, 16'd4, 1'b0, '0));
		repeat (7) send_request(make_request(ACT_PROTECT, nonzero_ident(), 16'd8, 1'b0, '0));
		send_request(make_request(ACT_PROTECT, 32'hABC, 16'd8, 1'b0, '0));
		send_request(make_request(ACT_UNPROTECT, '0, 16'd4, 1'b0, '0));
		send_request(make_request(ACT_CHECK, '0, 16'd0, 1'b0, 32'hFFFF_FFFF));
		send_request(make_request(ACT_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF));
		send_request(make_request(ACT_CHECK, 32'hFFFF_FFFF, 16'd0, 1'b1, 32'h5555_5555));
		send_request(make_request(ACT_UNPROTECT, 32'h5555_5555, 16'd4, 1'b0, '0));
		send_request(make_request(ACT_UNPROTECT, 32'h1, 16'd4, 1'b0, '0));
		send_request(make_request(ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
		for (int k = 0; k < 4; k++) begin
			send_request(make_request(ACT_UNDEFINED | 3'(k), $urandom(), 16'hFFFF, 1'b0,
			                          32'hFFFF_FFFF));
		end
		drain();

		// Random: long result hold-off first so the input backs up
		hold_request = HOLD_OFF_CYCLES;
		run_phase(480, 0, 0);
		run_phase(480, 52, 0);
		run_phase(480, 0, 52);
		run_phase(480, 34, 34);

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### protected_id_match_table.f
src/pimt_pkg.sv
src/pimt_ctrl.sv
src/pimt_dp.sv
src/protected_id_match_table.sv
tb/tb.sv
